// File: rtl/k_way_sorted_run_merger_top_defines.svh
// Assertion macros shared by the merger checker.
`ifndef K_WAY_SORTED_RUN_MERGER_TOP_DEFINES_SVH
`define K_WAY_SORTED_RUN_MERGER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kwm assertion failed");

// Next-cycle implication, checked out of reset.
`define KWM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kwm assertion failed");

`endif

// File: rtl/kwm_pkg.sv
// Shared types and constants for the k-way sorted run merger.
package kwm_pkg;

    localparam int KEY_W      = 32;
    localparam int RUN_IDX_W  = 2;
    localparam int MAX_RUN_W  = 4;
    localparam int MAX_SLOT_W = 6;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_MERGE = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_PRIME     = 7'b0000010,
        S_PRIME_LD  = 7'b0000100,
        S_PICK      = 7'b0001000,
        S_REFILL    = 7'b0010000,
        S_EMIT_RD   = 7'b0100000,
        S_EMIT_WAIT = 7'b1000000
    } state_t;

    // Access to the run store: one write or one read per cycle.
    typedef struct packed {
        logic                    wr_en;
        logic                    rd_en;
        logic [MAX_RUN_W-1:0]    run;
        logic [MAX_SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]        wdata;
    } store_req_t;

endpackage

// File: rtl/kwm_in_if.sv
// Request channel carrying load and merge requests.
interface kwm_in_if;
    import kwm_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [RUN_IDX_W-1:0]        run_index;
    logic signed [KEY_W-1:0]     value;

    modport source (output valid, output func, output run_index, output value, input ready);
    modport sink   (input valid, input func, input run_index, input value, output ready);
endinterface

// File: rtl/kwm_out_if.sv
// Result channel carrying merged keys.
interface kwm_out_if;
    import kwm_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [KEY_W-1:0]     key_out;
    logic [RUN_IDX_W-1:0]        source_run;
    logic                        is_last;
    logic                        overflowed;

    modport source (output valid, output key_out, output source_run, output is_last,
                    output overflowed, input ready);
    modport sink   (input valid, input key_out, input source_run, input is_last,
                    input overflowed, output ready);
endinterface

// File: rtl/k_way_sorted_run_merger_top.sv
// A load is written to the store RAM while idle; loads are taken one per cycle while no merge runs.
// Merge: the run heads are fetched from the store RAM one run at a time, then for each key the
// minimum head is picked and its run refilled over the store read port, then each result is read
// back from the merge buffer, largest first, into the output register, which a stalled sink holds.
// Reset clears run fills, head cursors, the overflow flag and control; RAMs keep contents.
module k_way_sorted_run_merger_top
    import kwm_pkg::*;
#(
    parameter int NUM_RUNS  = 4,
    parameter int RUN_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    kwm_in_if.sink      item,
    kwm_out_if.source   result
);

    localparam int TOTAL = NUM_RUNS * RUN_DEPTH;
    localparam int AW    = $clog2(TOTAL);
    localparam int RW    = $clog2(NUM_RUNS);
    localparam int FW    = $clog2(RUN_DEPTH + 1);
    localparam int CW    = $clog2(TOTAL + 1);
    localparam int BW    = RW + KEY_W;

    state_t                  state_reg, state_next;
    logic [FW-1:0]           fill_reg   [NUM_RUNS];
    logic [FW-1:0]           cursor_reg [NUM_RUNS];
    logic signed [KEY_W-1:0] head_reg   [NUM_RUNS];
    logic                    ovf_reg;
    logic                    ovf_out_reg;
    logic [CW-1:0]           cnt_reg;
    logic [AW-1:0]           emit_idx_reg;
    logic [RW-1:0]           run_ptr_reg;

    logic                    out_valid_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic [RUN_IDX_W-1:0]    out_src_reg;
    logic                    out_last_reg;
    logic                    out_ovf_reg;

    logic                    in_acc;
    logic [RW-1:0]           run_idx;
    logic                    run_ok;
    logic                    found;
    logic [RW-1:0]           best_run;
    logic signed [KEY_W-1:0] best_val;
    logic [FW-1:0]           best_next;
    logic                    out_free;
    store_req_t              store_req;
    logic [KEY_W-1:0]        store_rdata;
    logic                    buf_wr_en;
    logic                    buf_rd_en;
    logic [BW-1:0]           buf_rd_data;

    assign item.ready = (state_reg == S_IDLE);
    assign in_acc     = item.valid && item.ready;
    assign run_idx    = RW'(item.run_index);
    assign run_ok     = (32'(item.run_index) < NUM_RUNS) && (fill_reg[run_idx] < FW'(RUN_DEPTH));
    assign out_free   = !out_valid_reg || result.ready;

    // Smallest head among runs that still hold keys; ties go to the lower run.
    always_comb
    begin
        found    = 1'b0;
        best_run = '0;
        best_val = '0;
        for (int r = 0; r < NUM_RUNS; r++)
        begin
            if (cursor_reg[r] < fill_reg[r])
            begin
                if (!found || (head_reg[r] < best_val))
                begin
                    found    = 1'b1;
                    best_run = RW'(r);
                    best_val = head_reg[r];
                end
            end
        end
    end

    assign best_next = cursor_reg[best_run] + FW'(1);

    always_comb
    begin
        store_req = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (item.func == FUNC_LOAD) && run_ok)
                begin
                    store_req.wr_en = 1'b1;
                    store_req.run   = MAX_RUN_W'(run_idx);
                    store_req.slot  = MAX_SLOT_W'(fill_reg[run_idx]);
                    store_req.wdata = item.value;
                end
            end
            S_PRIME:
            begin
                store_req.rd_en = 1'b1;
                store_req.run   = MAX_RUN_W'(run_ptr_reg);
            end
            S_PICK:
            begin
                if (found && (best_next < fill_reg[best_run]))
                begin
                    store_req.rd_en = 1'b1;
                    store_req.run   = MAX_RUN_W'(best_run);
                    store_req.slot  = MAX_SLOT_W'(best_next);
                end
            end
            default:
            begin
                store_req = '0;
            end
        endcase
    end

    kwm_run_store #(
        .NUM_RUNS  (NUM_RUNS),
        .RUN_DEPTH (RUN_DEPTH)
    ) u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (store_rdata)
    );

    assign buf_wr_en = (state_reg == S_PICK) && found;
    assign buf_rd_en = (state_reg == S_EMIT_RD);

    kwm_merge_buf #(
        .DEPTH (TOTAL),
        .AW    (AW),
        .DW    (BW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (AW'(cnt_reg)),
        .wr_data ({best_run, best_val}),
        .rd_en   (buf_rd_en),
        .rd_addr (emit_idx_reg),
        .rd_data (buf_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (item.func == FUNC_MERGE))
                begin
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                state_next = S_PRIME_LD;
            end
            S_PRIME_LD:
            begin
                state_next = (run_ptr_reg == RW'(NUM_RUNS - 1)) ? S_PICK : S_PRIME;
            end
            S_PICK:
            begin
                if (found)
                begin
                    state_next = S_REFILL;
                end
                else
                begin
                    state_next = (cnt_reg == '0) ? S_IDLE : S_EMIT_RD;
                end
            end
            S_REFILL:
            begin
                state_next = S_PICK;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_free)
                begin
                    state_next = (emit_idx_reg == '0) ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ovf_reg      <= 1'b0;
            ovf_out_reg  <= 1'b0;
            cnt_reg      <= '0;
            emit_idx_reg <= '0;
            run_ptr_reg  <= '0;
            for (int r = 0; r < NUM_RUNS; r++)
            begin
                fill_reg[r]   <= '0;
                cursor_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (item.func == FUNC_LOAD)
                        begin
                            if (run_ok)
                            begin
                                fill_reg[run_idx] <= fill_reg[run_idx] + FW'(1);
                            end
                            else
                            begin
                                ovf_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            cnt_reg     <= '0;
                            run_ptr_reg <= '0;
                            for (int r = 0; r < NUM_RUNS; r++)
                            begin
                                cursor_reg[r] <= '0;
                            end
                        end
                    end
                end
                S_PRIME_LD:
                begin
                    run_ptr_reg <= run_ptr_reg + RW'(1);
                end
                S_PICK:
                begin
                    if (found)
                    begin
                        cursor_reg[best_run] <= best_next;
                        run_ptr_reg          <= best_run;
                        cnt_reg              <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        // Merge done: runs emptied, drop flag latched for the results.
                        ovf_out_reg  <= ovf_reg;
                        ovf_reg      <= 1'b0;
                        emit_idx_reg <= AW'(cnt_reg - CW'(1));
                        for (int r = 0; r < NUM_RUNS; r++)
                        begin
                            fill_reg[r]   <= '0;
                            cursor_reg[r] <= '0;
                        end
                    end
                end
                S_EMIT_WAIT:
                begin
                    if (out_free)
                    begin
                        emit_idx_reg <= emit_idx_reg - AW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Head registers are payload: loaded from the store in the cycle after the read is issued.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_PRIME_LD) || (state_reg == S_REFILL))
        begin
            head_reg[run_ptr_reg] <= store_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_EMIT_WAIT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_EMIT_WAIT) && out_free)
        begin
            out_key_reg  <= buf_rd_data[KEY_W-1:0];
            out_src_reg  <= RUN_IDX_W'(buf_rd_data[BW-1:KEY_W]);
            out_last_reg <= (emit_idx_reg == '0);
            out_ovf_reg  <= ovf_out_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.key_out    = out_key_reg;
    assign result.source_run = out_src_reg;
    assign result.is_last    = out_last_reg;
    assign result.overflowed = out_ovf_reg;

endmodule

// File: rtl/kwm_run_store.sv
// Run store: all runs in one synchronous RAM, addressed by run and slot.
module kwm_run_store
    import kwm_pkg::*;
#(
    parameter int NUM_RUNS  = 4,
    parameter int RUN_DEPTH = 16
)
(
    input  logic                clk,
    input  store_req_t          req,
    output logic [KEY_W-1:0]    rdata
);

    localparam int TOTAL = NUM_RUNS * RUN_DEPTH;
    localparam int AW    = $clog2(TOTAL);
    localparam int RW    = $clog2(NUM_RUNS);
    localparam int SW    = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

    logic [KEY_W-1:0] mem [TOTAL];
    logic [KEY_W-1:0] rdata_reg;
    logic [AW-1:0]    addr;

    assign addr = AW'(req.run[RW-1:0]) * AW'(RUN_DEPTH) + AW'(req.slot[SW-1:0]);

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/kwm_merge_buf.sv
// Merge buffer: ascending merged keys with their run, read back in reverse.
module kwm_merge_buf
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 34
)
(
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [DW-1:0]   wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output logic [DW-1:0]   rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/kwm_checker.sv
// Port-level checks for the merger, bound to the top level.
`include "k_way_sorted_run_merger_top_defines.svh"

module kwm_checker
    import kwm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [KEY_W-1:0]     out_key,
    input logic                 out_last,
    input logic                 out_ovf
);

    // A stalled result holds.
    `KWM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_key))

    // No new request while a merge still has results to deliver.
    `KWM_ASSERT_IMP(a_busy_merge, clk, rst_n, out_valid && !out_last, !in_ready)

    // Drop flag is the same on every result of one merge.
    `KWM_ASSERT_NXT(a_ovf_const, clk, rst_n, out_valid && out_ready && !out_last,
                    !out_valid || (out_ovf == $past(out_ovf)))

    // Last flag holds while stalled.
    `KWM_ASSERT_NXT(a_last_hold, clk, rst_n, out_valid && !out_ready, $stable(out_last))

endmodule

bind k_way_sorted_run_merger_top kwm_checker u_kwm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_key   (result.key_out),
    .out_last  (result.is_last),
    .out_ovf   (result.overflowed)
);
